[sv/oik_pkg.sv]
// Shared types, widths, register codes and rounding helpers for the omni wheel IK core.
package oik_pkg;

  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 19;
  localparam int SPEED_W = 20;
  localparam int SCALE_W = 17;
  localparam int QUO_W   = 16;
  localparam int REM_W   = SPEED_W + 1;
  localparam int SUM_W   = 35;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam int IN_DATA_W  = 3 * VEL_W;
  localparam int OUT_FIELDS_W = 4 * SPEED_W + SCALE_W;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int DIV_BITS_DEF = 2;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM  = 2'd2;

  localparam logic [GAIN_W-1:0]  TRANS_GAIN_RST = 16'd1024;
  localparam logic [GAIN_W-1:0]  ROT_GAIN_RST   = 16'd1024;
  localparam logic [LIMIT_W-1:0] SPEED_LIM_RST  = 19'd524287;

  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 20'h7FFFF;
  localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 20'h80000;
  localparam logic [SCALE_W-1:0] SCALE_ONE     = 17'h10000;

  typedef logic [SPEED_W-1:0] speed_t;  // two's complement Q10.10
  typedef logic [SPEED_W-1:0] mag_t;    // unsigned magnitude, up to 2^19

  // wheel order: 0 front-left, 1 front-right, 2 rear-left, 3 rear-right
  typedef struct packed {
    speed_t [3:0] spd;
    mag_t   [3:0] mag;
    mag_t         maxm;
    logic         scale_en;
  } wheel_t;

  typedef struct packed {
    wheel_t             w;
    logic [REM_W-1:0]   rem;
    logic [QUO_W-1:0]   quo;
  } div_t;

  // 22 fractional bits down to Q10.10, halves away from zero, saturating
  function automatic speed_t to_speed(input logic signed [SUM_W-1:0] s);
    logic             neg;
    logic [SUM_W-1:0] mag;
    logic [22:0]      r;
    speed_t           res;
    neg = s[SUM_W-1];
    mag = neg ? $unsigned(-s) : $unsigned(s);
    r   = 23'((mag + SUM_W'(2048)) >> 12);
    if (neg) begin
      res = (r > 23'd524288) ? SPEED_NEG_MAX : speed_t'(23'd0 - r);
    end else begin
      res = (r > 23'd524287) ? SPEED_POS_MAX : speed_t'(r);
    end
    return res;
  endfunction

  function automatic mag_t mag_of(input speed_t w);
    return w[SPEED_W-1] ? mag_t'(20'd0 - w) : mag_t'(w);
  endfunction

endpackage

[sv/oik_speed_pipe.sv]
// Three-stage front end: gain multiplies, wheel mixing with round/saturate, max magnitude.
module oik_speed_pipe (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [oik_pkg::GAIN_W-1:0]     trans_gain,
  input  logic [oik_pkg::GAIN_W-1:0]     rot_gain,
  input  logic [oik_pkg::LIMIT_W-1:0]    speed_limit,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [oik_pkg::IN_DATA_W-1:0]  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output oik_pkg::wheel_t                out_wheel
);
  import oik_pkg::*;

  logic va_r, vb_r, vc_r;
  logic rdy_a, rdy_b, rdy_c;

  logic signed [VEL_W-1:0] vx, vy, wz;
  logic signed [VEL_W:0]   dif17, sum17;
  logic signed [33:0]      a_diff_nxt, a_sum_nxt;
  logic signed [32:0]      a_rot_nxt;
  logic signed [33:0]      a_diff_r, a_sum_r;
  logic signed [32:0]      a_rot_r;

  logic signed [SUM_W-1:0] t_diff_m, t_sum_p, t_sum_m, t_diff_p;
  speed_t [3:0]            b_spd_nxt, b_spd_r;
  mag_t   [3:0]            b_mag_nxt, b_mag_r;

  mag_t   m01, m23, maxm;
  wheel_t c_nxt, c_r;

  assign rdy_c    = ~vc_r | out_ready;
  assign rdy_b    = ~vb_r | rdy_c;
  assign rdy_a    = ~va_r | rdy_b;
  assign in_ready = rdy_a;

  // stage A: three gain products
  assign vx    = in_data[VEL_W-1:0];
  assign vy    = in_data[2*VEL_W-1:VEL_W];
  assign wz    = in_data[3*VEL_W-1:2*VEL_W];
  assign dif17 = (VEL_W+1)'(vx) - (VEL_W+1)'(vy);
  assign sum17 = (VEL_W+1)'(vx) + (VEL_W+1)'(vy);
  assign a_diff_nxt = dif17 * $signed({1'b0, trans_gain});
  assign a_sum_nxt  = sum17 * $signed({1'b0, trans_gain});
  assign a_rot_nxt  = wz * $signed({1'b0, rot_gain});

  // stage B: mix, round to Q10.10, saturate
  assign t_diff_m = SUM_W'(a_diff_r) - SUM_W'(a_rot_r);
  assign t_sum_p  = SUM_W'(a_sum_r)  + SUM_W'(a_rot_r);
  assign t_sum_m  = SUM_W'(a_sum_r)  - SUM_W'(a_rot_r);
  assign t_diff_p = SUM_W'(a_diff_r) + SUM_W'(a_rot_r);

  always_comb begin
    b_spd_nxt[0] = to_speed(t_diff_m);
    b_spd_nxt[1] = to_speed(t_sum_p);
    b_spd_nxt[2] = to_speed(t_sum_m);
    b_spd_nxt[3] = to_speed(t_diff_p);
    for (int i = 0; i < 4; i++) begin
      b_mag_nxt[i] = mag_of(b_spd_nxt[i]);
    end
  end

  // stage C: largest magnitude and limit check
  assign m01  = (b_mag_r[0] > b_mag_r[1]) ? b_mag_r[0] : b_mag_r[1];
  assign m23  = (b_mag_r[2] > b_mag_r[3]) ? b_mag_r[2] : b_mag_r[3];
  assign maxm = (m01 > m23) ? m01 : m23;

  always_comb begin
    c_nxt.spd      = b_spd_r;
    c_nxt.mag      = b_mag_r;
    c_nxt.maxm     = maxm;
    c_nxt.scale_en = maxm > mag_t'(speed_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_diff_r <= a_diff_nxt;
      a_sum_r  <= a_sum_nxt;
      a_rot_r  <= a_rot_nxt;
    end
    if (rdy_b && va_r) begin
      b_spd_r <= b_spd_nxt;
      b_mag_r <= b_mag_nxt;
    end
    if (rdy_c && vb_r) begin
      c_r <= c_nxt;
    end
  end

  assign out_valid = vc_r;
  assign out_wheel = c_r;

endmodule

[sv/oik_div_pipe.sv]
// Pipelined restoring divider: scale = floor(limit * 2^16 / max), DIV_BITS quotient bits a stage.
module oik_div_pipe #(
  parameter int DIV_BITS = oik_pkg::DIV_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [oik_pkg::LIMIT_W-1:0]  speed_limit,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  oik_pkg::wheel_t              in_wheel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output oik_pkg::div_t                out_div
);
  import oik_pkg::*;

  localparam int DivStages = QUO_W / DIV_BITS;

  logic [DivStages-1:0] vld_r;
  logic [DivStages:0]   rdy;
  div_t                 stg_r [DivStages];
  div_t                 stg_nxt [DivStages];
  div_t                 init_d;

  function automatic div_t div_step(input div_t d);
    div_t             res;
    logic [REM_W-1:0] r2;
    res = d;
    for (int k = 0; k < DIV_BITS; k++) begin
      r2 = {res.rem[REM_W-2:0], 1'b0};
      if (r2 >= REM_W'(res.w.maxm)) begin
        res.rem = r2 - REM_W'(res.w.maxm);
        res.quo = {res.quo[QUO_W-2:0], 1'b1};
      end else begin
        res.rem = r2;
        res.quo = {res.quo[QUO_W-2:0], 1'b0};
      end
    end
    return res;
  endfunction

  // remainder starts at the limit, which is below max whenever the quotient is used
  always_comb begin
    init_d.w   = in_wheel;
    init_d.rem = REM_W'(speed_limit);
    init_d.quo = '0;
  end

  always_comb begin
    rdy[DivStages] = out_ready;
    for (int g = DivStages - 1; g >= 0; g--) begin
      rdy[g] = ~vld_r[g] | rdy[g+1];
    end
  end

  assign in_ready = rdy[0];

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign stg_nxt[g] = div_step(init_d);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (rdy[g]) begin
          vld_r[g] <= in_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[g] && in_valid) stg_r[g] <= stg_nxt[g];
      end
    end else begin : g_rest
      assign stg_nxt[g] = div_step(stg_r[g-1]);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (rdy[g]) begin
          vld_r[g] <= vld_r[g-1];
        end
      end
      always_ff @(posedge clk) begin
        if (rdy[g] && vld_r[g-1]) stg_r[g] <= stg_nxt[g];
      end
    end
  end

  assign out_valid = vld_r[DivStages-1];
  assign out_div   = stg_r[DivStages-1];

endmodule

[sv/oik_scale_pipe.sv]
// Two-stage back end: magnitude times scale, then rounding, sign restore and output register.
module oik_scale_pipe (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  oik_pkg::div_t           in_div,
  output logic                    out_valid,
  input  logic                    out_ready,
  output oik_pkg::speed_t [3:0]   out_speed,
  output logic [oik_pkg::SCALE_W-1:0] out_scale
);
  import oik_pkg::*;

  localparam int ProdW = SPEED_W + QUO_W;

  logic vm_r, vo_r;
  logic rdy_m, rdy_o;

  logic [3:0][ProdW-1:0] m_prod_nxt, m_prod_r;
  speed_t [3:0]          m_spd_r;
  logic [QUO_W-1:0]      m_quo_r;
  logic                  m_en_r;

  speed_t [3:0]          o_spd_nxt, o_spd_r;
  logic [SCALE_W-1:0]    o_scale_nxt, o_scale_r;
  mag_t                  rm;

  assign rdy_o    = ~vo_r | out_ready;
  assign rdy_m    = ~vm_r | rdy_o;
  assign in_ready = rdy_m;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m_prod_nxt[i] = ProdW'(in_div.w.mag[i]) * ProdW'(in_div.quo);
    end
  end

  always_comb begin
    rm = '0;
    for (int i = 0; i < 4; i++) begin
      rm = mag_t'((m_prod_r[i] + ProdW'(32768)) >> 16);
      if (m_en_r) begin
        o_spd_nxt[i] = m_spd_r[i][SPEED_W-1] ? speed_t'(20'd0 - rm) : speed_t'(rm);
      end else begin
        o_spd_nxt[i] = m_spd_r[i];
      end
    end
    o_scale_nxt = m_en_r ? SCALE_W'(m_quo_r) : SCALE_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_m) vm_r <= in_valid;
      if (rdy_o) vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m && in_valid) begin
      m_prod_r <= m_prod_nxt;
      m_spd_r  <= in_div.w.spd;
      m_quo_r  <= in_div.quo;
      m_en_r   <= in_div.w.scale_en;
    end
    if (rdy_o && vm_r) begin
      o_spd_r   <= o_spd_nxt;
      o_scale_r <= o_scale_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_speed = o_spd_r;
  assign out_scale = o_scale_r;

endmodule

[sv/omni_wheel_inverse_kinematics_core.sv]
// Top level: config registers, front end, desaturation divider and scaling back end.
// Turns one body velocity command per transfer into four omni wheel speeds
// (Q10.10, front-left, front-right, rear-left, rear-right) plus the Q1.16
// desaturation scale applied to them. A command can be accepted every cycle
// unless the pipeline is stalled; a command passes 5 + 16/DIV_BITS register
// stages (13 with the default of 2), the 16-bit quotient divider resolving
// DIV_BITS bits per stage. All stages stall together from the output register
// back, and empty stages fill while the output waits.
// Config writes are always accepted and must only happen while no command
// is in flight.
module omni_wheel_inverse_kinematics_core #(
  parameter int DIV_BITS = oik_pkg::DIV_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // forward_velocity [15:0], lateral_velocity [31:16], yaw_rate [47:32]
  input  logic [oik_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // front_left_speed [19:0], front_right_speed [39:20], rear_left_speed [59:40],
  // rear_right_speed [79:60], applied_scale [96:80], zero [103:97]
  output logic [oik_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [oik_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [oik_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import oik_pkg::*;

  logic [GAIN_W-1:0]  trans_gain_r;
  logic [GAIN_W-1:0]  rot_gain_r;
  logic [LIMIT_W-1:0] speed_limit_r;

  logic   sp_valid, sp_ready;
  wheel_t sp_wheel;
  logic   dv_valid, dv_ready;
  div_t   dv_data;
  speed_t [3:0]       o_speed;
  logic [SCALE_W-1:0] o_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_gain_r  <= TRANS_GAIN_RST;
      rot_gain_r    <= ROT_GAIN_RST;
      speed_limit_r <= SPEED_LIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRANS_GAIN: trans_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_ROT_GAIN:   rot_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_SPEED_LIM:  speed_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  oik_speed_pipe u_speed (
    .clk         (clk),
    .rst_n       (rst_n),
    .trans_gain  (trans_gain_r),
    .rot_gain    (rot_gain_r),
    .speed_limit (speed_limit_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .out_valid   (sp_valid),
    .out_ready   (sp_ready),
    .out_wheel   (sp_wheel)
  );

  oik_div_pipe #(
    .DIV_BITS (DIV_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .speed_limit (speed_limit_r),
    .in_valid    (sp_valid),
    .in_ready    (sp_ready),
    .in_wheel    (sp_wheel),
    .out_valid   (dv_valid),
    .out_ready   (dv_ready),
    .out_div     (dv_data)
  );

  oik_scale_pipe u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_div    (dv_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_speed (o_speed),
    .out_scale (o_scale)
  );

  assign out_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), o_scale,
                      o_speed[3], o_speed[2], o_speed[1], o_speed[0]};

`ifndef SYNTHESIS
  // an empty output register means every stage can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o_scale <= SCALE_ONE)
    else $error("applied scale above one");

  a_scaled_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_scale != SCALE_ONE |->
      mag_of(o_speed[0]) <= mag_t'(speed_limit_r) &&
      mag_of(o_speed[1]) <= mag_t'(speed_limit_r) &&
      mag_of(o_speed[2]) <= mag_t'(speed_limit_r) &&
      mag_of(o_speed[3]) <= mag_t'(speed_limit_r))
    else $error("desaturated wheel speed above limit");

  a_zero_scale_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_scale == '0 |->
      o_speed[0] == '0 && o_speed[1] == '0 && o_speed[2] == '0 && o_speed[3] == '0)
    else $error("nonzero speed with zero scale");
`endif

endmodule
